@@ src/olssc_pkg.sv @@
package olssc_pkg;

	localparam int unsigned FULL_TURN = 36000;

	localparam int unsigned ANGLE_W = 16;
	localparam int unsigned STEP_W = 3;
	localparam int unsigned PHASE_W = 2;
	localparam int unsigned DUTY_W = 16;
	localparam int unsigned SPEED_W = 16;
	localparam int unsigned GAIN_W = 10;
	localparam int unsigned GAIN_SHIFT = 10;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [DUTY_W-1:0] DRIVE_LEVEL_RST = 16'd100;
	localparam logic [GAIN_W-1:0] TICK_GAIN_RST = 10'd1;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LEVEL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_GAIN = 1'd1;

	// Commutation thresholds, in twelfths of a turn.
	localparam logic [ANGLE_W-1:0] TH_1 = ANGLE_W'(FULL_TURN * 1 / 12);
	localparam logic [ANGLE_W-1:0] TH_3 = ANGLE_W'(FULL_TURN * 3 / 12);
	localparam logic [ANGLE_W-1:0] TH_5 = ANGLE_W'(FULL_TURN * 5 / 12);
	localparam logic [ANGLE_W-1:0] TH_7 = ANGLE_W'(FULL_TURN * 7 / 12);
	localparam logic [ANGLE_W-1:0] TH_9 = ANGLE_W'(FULL_TURN * 9 / 12);
	localparam logic [ANGLE_W-1:0] TH_11 = ANGLE_W'(FULL_TURN * 11 / 12);

	// Phase and comparator codes.
	localparam logic [PHASE_W-1:0] PH_A = 2'd0;
	localparam logic [PHASE_W-1:0] PH_B = 2'd1;
	localparam logic [PHASE_W-1:0] PH_C = 2'd2;
	localparam logic [PHASE_W-1:0] CMP_FIRST = 2'd0;
	localparam logic [PHASE_W-1:0] CMP_SECOND = 2'd1;
	localparam logic [PHASE_W-1:0] CMP_THIRD = 2'd2;

	typedef enum logic [5:0] {
		ST_0 = 6'b000001,
		ST_1 = 6'b000010,
		ST_2 = 6'b000100,
		ST_3 = 6'b001000,
		ST_4 = 6'b010000,
		ST_5 = 6'b100000
	} step_t;

	typedef struct packed {
		logic                valid;
		logic [PHASE_W-1:0]  drive_phase;
		logic [DUTY_W-1:0]   drive_duty;
		logic [PHASE_W-1:0]  float_phase;
		logic [PHASE_W-1:0]  sense_comparator;
	} action_t;

	function automatic logic [STEP_W-1:0] step_code(input step_t st);
		logic [STEP_W-1:0] code;
		unique case (st)
			ST_0: code = 3'd0;
			ST_1: code = 3'd1;
			ST_2: code = 3'd2;
			ST_3: code = 3'd3;
			ST_4: code = 3'd4;
			ST_5: code = 3'd5;
			default: code = 3'd0;
		endcase
		return code;
	endfunction

endpackage

@@ src/olssc_seq.sv @@
module olssc_seq (
	input  olssc_pkg::step_t                  step,
	input  logic [olssc_pkg::ANGLE_W-1:0]     angle,
	input  logic [olssc_pkg::DUTY_W-1:0]      drive_level,
	output olssc_pkg::step_t                  step_next,
	output olssc_pkg::action_t                action
);
	import olssc_pkg::*;

	always_comb begin
		step_next = step;
		action = '0;
		unique case (step)
			ST_0: begin
				if (angle > TH_1) begin
					action = '{1'b1, PH_A, drive_level, PH_C, CMP_THIRD};
					step_next = ST_1;
				end
			end
			ST_1: begin
				if (angle > TH_3) begin
					action = '{1'b1, PH_C, '0, PH_B, CMP_SECOND};
					step_next = ST_2;
				end
			end
			ST_2: begin
				if (angle > TH_5) begin
					action = '{1'b1, PH_B, drive_level, PH_A, CMP_FIRST};
					step_next = ST_3;
				end
			end
			ST_3: begin
				if (angle > TH_7) begin
					action = '{1'b1, PH_A, '0, PH_C, CMP_THIRD};
					step_next = ST_4;
				end
			end
			ST_4: begin
				if (angle > TH_9) begin
					action = '{1'b1, PH_C, drive_level, PH_B, CMP_SECOND};
					step_next = ST_5;
				end
			end
			ST_5: begin
				// The last step keeps firing while past 330 degrees and rearms
				// once the angle has wrapped below 270 degrees.
				if (angle > TH_11) begin
					action = '{1'b1, PH_B, '0, PH_A, CMP_FIRST};
				end
				if (angle < TH_9) begin
					step_next = ST_0;
				end
			end
			default: step_next = ST_0;
		endcase
	end

endmodule

@@ src/olssc_integ.sv @@
module olssc_integ (
	input  logic [olssc_pkg::ANGLE_W-1:0]        angle,
	input  logic signed [olssc_pkg::SPEED_W-1:0] speed,
	input  logic [olssc_pkg::GAIN_W-1:0]         tick_gain,
	output logic [olssc_pkg::ANGLE_W-1:0]        angle_next
);
	import olssc_pkg::*;

	localparam int unsigned PROD_W = SPEED_W + GAIN_W;
	localparam int unsigned SUM_W = ANGLE_W + 3;
	localparam logic signed [SUM_W-1:0] TURN = SUM_W'(FULL_TURN);

	logic signed [PROD_W-1:0] spd_x;
	logic signed [PROD_W-1:0] gain_x;
	logic signed [PROD_W-1:0] prod;
	logic signed [SUM_W-1:0]  delta;
	logic signed [SUM_W-1:0]  na0;
	logic signed [SUM_W-1:0]  na1;
	logic signed [SUM_W-1:0]  na2;
	logic signed [SUM_W-1:0]  na3;

	always_comb begin
		spd_x = PROD_W'(speed);
		gain_x = $signed(PROD_W'(tick_gain));
		prod = spd_x * gain_x;
		// Dropping the low bits of a two's complement product rounds toward
		// minus infinity.
		delta = SUM_W'($signed(prod[PROD_W-1:GAIN_SHIFT]));
		na0 = $signed(SUM_W'(angle)) + delta;
		na1 = (na0 < 0) ? na0 + TURN : na0;
		na2 = (na1 > TURN) ? na1 - TURN : na1;
		if (na2 < 0) begin
			na3 = '0;
		end else if (na2 > TURN) begin
			na3 = TURN;
		end else begin
			na3 = na2;
		end
		angle_next = na3[ANGLE_W-1:0];
	end

endmodule

@@ src/open_loop_six_step_commutator.sv @@
// Channel  Direction  Handshake            Word
// in       input      in_valid/in_stall    speed
// out      output     out_valid/out_stall  angle_out, step_out, action_valid, drive_phase,
//                                          drive_duty, float_phase, sense_comparator
// cfg      input      cfg_we               cfg_index, cfg_data
//
// One word per cycle sustained while the output does not stall.
// The sequencer and the multiply, add and wrap of the angle sit between the input
// register and the result register, and the angle and step update as the result loads.
// Reset clears the angle and step and loads drive_level 100 and tick_gain 1.
// A stall on the output holds the result and, with the input register full, the input.
module open_loop_six_step_commutator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [olssc_pkg::SPEED_W-1:0] speed,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [olssc_pkg::ANGLE_W-1:0]        angle_out,
	output logic [olssc_pkg::STEP_W-1:0]         step_out,
	output logic                                 action_valid,
	output logic [olssc_pkg::PHASE_W-1:0]        drive_phase,
	output logic [olssc_pkg::DUTY_W-1:0]         drive_duty,
	output logic [olssc_pkg::PHASE_W-1:0]        float_phase,
	output logic [olssc_pkg::PHASE_W-1:0]        sense_comparator,
	input  logic                                 cfg_we,
	input  logic [olssc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [olssc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import olssc_pkg::*;

	logic [DUTY_W-1:0]          drive_level_q;
	logic [GAIN_W-1:0]          tick_gain_q;
	logic [ANGLE_W-1:0]         angle_q;
	step_t                      step_q;

	logic                       valid_s1;
	logic signed [SPEED_W-1:0]  speed_s1;
	logic                       valid_s2;
	logic [ANGLE_W-1:0]         angle_s2;
	logic [STEP_W-1:0]          step_s2;
	action_t                    action_s2;

	step_t                      step_next;
	action_t                    action;
	logic [ANGLE_W-1:0]         angle_next;
	logic                       advance;

	olssc_seq u_seq (
		.step        (step_q),
		.angle       (angle_q),
		.drive_level (drive_level_q),
		.step_next   (step_next),
		.action      (action)
	);

	olssc_integ u_integ (
		.angle      (angle_q),
		.speed      (speed_s1),
		.tick_gain  (tick_gain_q),
		.angle_next (angle_next)
	);

	// The input register moves on whenever the result register is free or being read.
	assign advance = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_level_q <= DRIVE_LEVEL_RST;
			tick_gain_q <= TICK_GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DRIVE_LEVEL: drive_level_q <= cfg_data;
				REG_TICK_GAIN:   tick_gain_q <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			angle_q <= '0;
			step_q <= ST_0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					angle_q <= angle_next;
					step_q <= step_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			speed_s1 <= speed;
		end
		if (advance && valid_s1) begin
			angle_s2 <= angle_next;
			step_s2 <= step_code(step_next);
			action_s2 <= action;
		end
	end

	assign out_valid = valid_s2;
	assign angle_out = angle_s2;
	assign step_out = step_s2;
	assign action_valid = action_s2.valid;
	assign drive_phase = action_s2.drive_phase;
	assign drive_duty = action_s2.drive_duty;
	assign float_phase = action_s2.float_phase;
	assign sense_comparator = action_s2.sense_comparator;

	a_phases_differ: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && action_valid) |-> (drive_phase != float_phase))
		else $error("action drives and floats the same phase");

	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !action_valid) |->
		(drive_phase == PH_A && drive_duty == '0 && float_phase == PH_A &&
		sense_comparator == CMP_FIRST))
		else $error("action fields set without an action");

	a_angle_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (angle_out <= ANGLE_W'(FULL_TURN)))
		else $error("angle outside one turn");

	a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a blocked result");

	a_state_tracks_output: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1) |=> (angle_out == angle_q && step_out == step_code(step_q)))
		else $error("result and stored state disagree");

endmodule
